// ----- hw/rtl/cbrb_pkg.sv -----
// shared types and constants of the chunked byte ring buffer
`timescale 1ns / 1ps

package cbrb_pkg;

    localparam int OP_W   = 2;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 13;
    localparam int LANE_W = 3;

    localparam logic [CNT_W-1:0] CAP_MIN   = 13'd8;
    localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

    typedef enum logic [OP_W-1:0] {
        OP_FLUSH = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE     = 2'd0,
        STAT_UNDERRUN = 2'd1,
        STAT_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

// ----- hw/rtl/chunked_byte_ring_buffer_core.sv -----
// byte ring buffer with all-or-nothing chunk writes and reads over one byte memory
`timescale 1ns / 1ps

// Each item is a flush, a write or a read of up to CHUNK_BYTES bytes. The bytes
// sit in one single-port-per-side byte memory that moves one byte per cycle, so
// one item occupies the block until its byte walk is done: a flush, a refused,
// zero-length or unused request goes from idle straight to finish, a write walks
// its bytes and then finishes, and a read walks its bytes, drains the registered
// memory read and then finishes. A new item is accepted while the previous
// result still waits in the output register. A capacity write empties the
// buffer; values below 8 act as 8 and values above STORE_DEPTH act as
// STORE_DEPTH. Results carry the status in m_tuser and the moved length, read
// bytes and level in m_tdata.

module chunked_byte_ring_buffer_core #(
    parameter int STORE_DEPTH = 4096,
    parameter int CHUNK_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,   // capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,       // chunk_length[3:0], data_bytes[67:4], zero pad
    input  logic [1:0]  s_tuser,       // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,       // moved_length[3:0], read_bytes[67:4],
                                       // level[80:68], zero pad
    output logic [1:0]  m_tuser        // status[1:0]
);

    localparam int PW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int AW = (PW + 1 > cbrb_pkg::CNT_W) ? PW + 1 : cbrb_pkg::CNT_W;
    localparam int DEPTH_CLAMP = (STORE_DEPTH > 8191) ? 8191 : STORE_DEPTH;
    localparam logic [cbrb_pkg::CNT_W-1:0] DEPTH_CAP = cbrb_pkg::CNT_W'(DEPTH_CLAMP);
    localparam logic [cbrb_pkg::CNT_W-1:0] CAP_INIT =
        (DEPTH_CAP < cbrb_pkg::CAP_RESET) ? DEPTH_CAP : cbrb_pkg::CAP_RESET;
    localparam logic [cbrb_pkg::LEN_W-1:0] CHUNK_MAX = cbrb_pkg::LEN_W'(CHUNK_BYTES);

    function automatic logic [cbrb_pkg::CNT_W-1:0] f_clamp(
        input logic [cbrb_pkg::CNT_W-1:0] c
    );
        if (c < cbrb_pkg::CAP_MIN) return cbrb_pkg::CAP_MIN;
        if (c > DEPTH_CAP) return DEPTH_CAP;
        return c;
    endfunction

    function automatic logic [PW-1:0] f_advance(
        input logic [PW-1:0]              p,
        input logic [cbrb_pkg::CNT_W-1:0] c
    );
        logic [AW-1:0] nx;
        nx = AW'(p) + AW'(1);
        if (nx >= AW'(c)) return '0;
        return nx[PW-1:0];
    endfunction

    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] r_mem_q;

    cbrb_pkg::t_state r_state, n_state;

    logic [cbrb_pkg::CNT_W-1:0]  r_cap;
    logic [cbrb_pkg::CNT_W-1:0]  r_count;
    logic [PW-1:0]               r_rp;
    logic [PW-1:0]               r_wp;
    logic [cbrb_pkg::LEN_W-1:0]  r_left;
    logic                        r_q_vld;
    logic [cbrb_pkg::LANE_W-1:0] r_cidx;
    logic [cbrb_pkg::DATA_W-1:0] r_wdata;
    logic [cbrb_pkg::DATA_W-1:0] r_rd;
    cbrb_pkg::t_status           r_status;
    logic [cbrb_pkg::LEN_W-1:0]  r_moved;

    logic                        r_m_valid;
    cbrb_pkg::t_status           r_m_status;
    logic [cbrb_pkg::LEN_W-1:0]  r_m_moved;
    logic [cbrb_pkg::DATA_W-1:0] r_m_rd;
    logic [cbrb_pkg::CNT_W-1:0]  r_m_level;

    cbrb_pkg::t_op               in_op;
    logic [cbrb_pkg::LEN_W-1:0]  in_len_raw;
    logic [cbrb_pkg::LEN_W-1:0]  in_len;
    logic [cbrb_pkg::DATA_W-1:0] in_data;
    logic                        accept;
    logic                        wr_ok;
    logic                        rd_ok;
    logic                        mem_we;
    logic                        mem_re;
    logic                        load_out;

    assign in_op      = cbrb_pkg::t_op'(s_tuser);
    assign in_len_raw = s_tdata[3:0];
    assign in_len     = (in_len_raw > CHUNK_MAX) ? CHUNK_MAX : in_len_raw;
    assign in_data    = s_tdata[67:4];
    assign accept     = s_tvalid && s_tready;

    assign wr_ok = (in_len != '0) &&
                   (({1'b0, r_count} + 14'(in_len)) <= {1'b0, r_cap});
    assign rd_ok = (in_len != '0) && (r_count >= cbrb_pkg::CNT_W'(in_len));

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            cbrb_pkg::ST_IDLE:   s_tready = 1'b1;
            cbrb_pkg::ST_WRITE:  mem_we   = 1'b1;
            cbrb_pkg::ST_READ:   mem_re   = 1'b1;
            cbrb_pkg::ST_DRAIN:  ;
            cbrb_pkg::ST_FINISH: load_out = !r_m_valid || m_tready;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cbrb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = cbrb_pkg::ST_FINISH;
                    if (in_op == cbrb_pkg::OP_WRITE && wr_ok) n_state = cbrb_pkg::ST_WRITE;
                    if (in_op == cbrb_pkg::OP_READ && rd_ok)  n_state = cbrb_pkg::ST_READ;
                end
            end
            cbrb_pkg::ST_WRITE: begin
                if (r_left == 4'd1) n_state = cbrb_pkg::ST_FINISH;
            end
            cbrb_pkg::ST_READ: begin
                if (r_left == 4'd1) n_state = cbrb_pkg::ST_DRAIN;
            end
            cbrb_pkg::ST_DRAIN:  n_state = cbrb_pkg::ST_FINISH;
            cbrb_pkg::ST_FINISH: begin
                if (load_out) n_state = cbrb_pkg::ST_IDLE;
            end
            default: n_state = cbrb_pkg::ST_IDLE;
        endcase
    end

    // byte memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_store[r_wp] <= r_wdata[7:0];
        r_mem_q <= r_store[r_rp];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cbrb_pkg::ST_IDLE;
            r_cap     <= CAP_INIT;
            r_count   <= '0;
            r_rp      <= '0;
            r_wp      <= '0;
            r_left    <= '0;
            r_q_vld   <= 1'b0;
            r_cidx    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_q_vld <= mem_re;
            if (r_q_vld) r_cidx <= r_cidx + 3'd1;
            if (mem_we) r_wp <= f_advance(r_wp, r_cap);
            if (mem_re) r_rp <= f_advance(r_rp, r_cap);
            if (mem_we || mem_re) r_left <= r_left - 4'd1;
            if (accept) begin
                r_left <= in_len;
                r_cidx <= '0;
                case (in_op)
                    cbrb_pkg::OP_FLUSH: begin
                        r_count <= '0;
                        r_rp    <= '0;
                        r_wp    <= '0;
                    end
                    cbrb_pkg::OP_WRITE: begin
                        if (wr_ok) r_count <= r_count + cbrb_pkg::CNT_W'(in_len);
                    end
                    cbrb_pkg::OP_READ: begin
                        if (rd_ok) r_count <= r_count - cbrb_pkg::CNT_W'(in_len);
                    end
                    default: ;
                endcase
            end
            if (load_out) r_m_valid <= 1'b1;
            else if (m_tready) r_m_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cap   <= f_clamp(i_cfg_wdata);
                r_count <= '0;
                r_rp    <= '0;
                r_wp    <= '0;
            end
        end
    end

    // item payload and result register
    always_ff @(posedge i_clk) begin
        if (mem_we) r_wdata <= r_wdata >> 8;
        if (r_q_vld) r_rd[8*r_cidx +: 8] <= r_mem_q;
        if (accept) begin
            r_wdata  <= in_data;
            r_rd     <= '0;
            r_status <= cbrb_pkg::STAT_DONE;
            r_moved  <= '0;
            if (in_op == cbrb_pkg::OP_WRITE && in_len != '0) begin
                if (wr_ok) r_moved  <= in_len;
                else       r_status <= cbrb_pkg::STAT_OVERFLOW;
            end
            if (in_op == cbrb_pkg::OP_READ && in_len != '0) begin
                if (rd_ok) r_moved  <= in_len;
                else       r_status <= cbrb_pkg::STAT_UNDERRUN;
            end
        end
        if (load_out) begin
            r_m_status <= r_status;
            r_m_moved  <= r_moved;
            r_m_rd     <= r_rd;
            r_m_level  <= r_count;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_status;
    assign m_tdata  = {7'd0, r_m_level, r_m_rd, r_m_moved};

    a_level_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("level above capacity");

    a_ptr_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW'(r_rp) < AW'(r_cap)) && (AW'(r_wp) < AW'(r_cap)))
        else $error("pointer outside capacity");

    a_refused_moves_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != cbrb_pkg::STAT_DONE) |->
            (m_tdata[3:0] == 4'd0) && (m_tdata[67:4] == 64'd0))
        else $error("refused item reports moved bytes");

    a_pending_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbrb_pkg::ST_FINISH) && r_m_valid && !m_tready |=>
            (r_state == cbrb_pkg::ST_FINISH))
        else $error("result dropped while output is stalled");

endmodule
